### rtl/cbez_pkg.sv
`default_nettype none
package cbez_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 8;
    localparam int BISECT_STEPS = 18;

    localparam int QONE    = 1 << FRAC_BITS;
    localparam int TOL_RAW = (QONE + 500) / 1000;
    localparam int TOL     = (TOL_RAW > 0) ? TOL_RAW : 1;

    localparam int IN_W    = 18;
    localparam int OUT_W   = 19;
    localparam int CP_X_W  = 17;
    localparam int CP_Y_W  = 19;
    localparam int IDX_W   = 2;
    localparam int S_W     = FRAC_BITS + 1;
    localparam int COEF_W  = 24;
    localparam int ACC_W   = 28;
    localparam int DIV_W   = ACC_W + FRAC_BITS;
    localparam int NIT_W   = 5;
    localparam int BIT_W   = 6;
    localparam int CNT_W   = 6;

    localparam int OUT_MIN = -2 * QONE;
    localparam int OUT_MAX = 3 * QONE;

    typedef enum logic [IDX_W-1:0] {
        REG_CP1_X = 2'd0,
        REG_CP1_Y = 2'd1,
        REG_CP2_X = 2'd2,
        REG_CP2_Y = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] c0x;
        logic signed [COEF_W-1:0] c1x;
        logic signed [COEF_W-1:0] c2x;
        logic signed [COEF_W-1:0] c0y;
        logic signed [COEF_W-1:0] c1y;
        logic signed [COEF_W-1:0] c2y;
    } coef_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NX,
        S_NCHK,
        S_ND,
        S_NDCHK,
        S_NDIV,
        S_BX,
        S_BCHK,
        S_Y,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

### rtl/cubic_bezier_easing_solver.sv
// Cubic Bezier easing curve from (0,0) to (1,1), all values Q16 (signed, control-point x unsigned).
// Input channel: in_valid / in_stall with progress. A transaction is taken
// when in_valid is high and in_stall low; in_stall stays high while an item
// is being solved. Output channel: out_valid / out_stall with eased_value,
// held in an output register; the next input is taken while it waits.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// cp1_x, cp1_y, cp2_x, cp2_y; write only while the block is idle.
// Progress outside 0..1 is clamped to s = 0 or 1 and goes straight to y(s).
// Each Newton step evaluates x(s), then the slope, then divides on the
// 44-bit bit-serial divider. Each bisection step evaluates x(s) once, and
// the final y(s) follows. At most 8 Newton and 18 bisection steps are run;
// one item is in flight at a time.
// All polynomial arithmetic goes through one shared multiply-round-add unit; the divide has its own unit.
// Reset restores the linear curve and empties the output register.
// While out_stall is high the result holds and a finished item waits.
`default_nettype none
module cubic_bezier_easing_solver (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [cbez_pkg::IN_W-1:0]     progress,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed      [cbez_pkg::OUT_W-1:0]    eased_value,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [cbez_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic        [cbez_pkg::CP_Y_W-1:0]   cfg_data
);
    import cbez_pkg::*;

    state_t                   state_reg, state_next;
    logic [1:0]               ph_reg, ph_next;
    logic [S_W-1:0]           s_reg, s_next, t_reg, t_next;
    logic [S_W-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic signed [ACC_W-1:0]  err_reg, err_next;
    logic                     neg_reg, neg_next;
    logic [NIT_W-1:0]         nit_reg, nit_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  out_reg, out_next;

    coef_t                    coef;
    logic                     mac_en;
    logic signed [ACC_W-1:0]  mac_a, mac_c, acc, c0, c1, c2, diff, dabs;
    logic                     div_start, div_done;
    logic [DIV_W-1:0]         div_num, div_quo;
    logic [ACC_W-1:0]         div_den;
    logic signed [DIV_W+1:0]  qs, snew;
    logic [S_W-1:0]           nlo, nhi, mid;
    logic                     ysel, hit;

    cbez_coef u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    cbez_mac u_mac (
        .clk (clk),
        .en  (mac_en),
        .a   (mac_a),
        .s   (s_reg),
        .c   (mac_c),
        .acc (acc)
    );

    cbez_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign eased_value = out_reg;

    // operand select for the shared unit
    always_comb
    begin
        ysel   = (state_reg == S_Y);
        c0     = ACC_W'(ysel ? coef.c0y : coef.c0x);
        c1     = ACC_W'(ysel ? coef.c1y : coef.c1x);
        c2     = ACC_W'(ysel ? coef.c2y : coef.c2x);
        mac_en = (state_reg == S_NX) || (state_reg == S_ND) ||
                 (state_reg == S_BX) || (state_reg == S_Y);
        mac_a  = acc;
        mac_c  = '0;
        if (state_reg == S_ND)
        begin
            if (ph_reg == 2'd0)
            begin
                mac_a = ACC_W'(3 * c0);
                mac_c = ACC_W'(2 * c1);
            end
            else
                mac_c = c2;
        end
        else
        begin
            case (ph_reg)
                2'd0:
                begin
                    mac_a = c0;
                    mac_c = c1;
                end
                2'd1:    mac_c = c2;
                default: mac_c = '0;
            endcase
        end
    end

    always_comb
    begin
        diff    = acc - ACC_W'($signed({1'b0, t_reg}));
        dabs    = diff[ACC_W-1] ? -diff : diff;
        hit     = (dabs < ACC_W'(TOL));
        div_num = DIV_W'(err_reg[ACC_W-1] ? -err_reg : err_reg) << FRAC_BITS;
        div_den = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        qs      = (DIV_W+2)'($signed({1'b0, div_quo}));
        snew    = (DIV_W+2)'($signed({1'b0, s_reg})) - (neg_reg ? -qs : qs);
        nlo     = diff[ACC_W-1] ? s_reg : lo_reg;
        nhi     = diff[ACC_W-1] ? hi_reg : s_reg;
        mid     = nlo + ((nhi - nlo) >> 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        nit_next       = nit_reg;
        bit_next       = bit_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next   = S_W'($unsigned(progress));
                    lo_next  = '0;
                    hi_next  = S_W'(QONE);
                    nit_next = '0;
                    bit_next = '0;
                    ph_next  = '0;
                    if (progress[IN_W-1])
                    begin
                        s_next     = '0;
                        state_next = S_Y;
                    end
                    else if (progress > IN_W'(QONE))
                    begin
                        s_next     = S_W'(QONE);
                        state_next = S_Y;
                    end
                    else
                    begin
                        s_next     = S_W'($unsigned(progress));
                        state_next = (NEWTON_STEPS == 0) ? S_BX : S_NX;
                    end
                end
            end
            S_NX:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd2)
                begin
                    ph_next    = '0;
                    state_next = S_NCHK;
                end
            end
            S_NCHK:
            begin
                err_next   = diff;
                state_next = hit ? S_Y : S_ND;
            end
            S_ND:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd1)
                begin
                    ph_next    = '0;
                    state_next = S_NDCHK;
                end
            end
            S_NDCHK:
            begin
                if (acc == '0)
                    state_next = S_BX;
                else
                begin
                    neg_next   = err_reg[ACC_W-1] ^ acc[ACC_W-1];
                    div_start  = 1'b1;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (div_done)
                begin
                    if (snew[DIV_W+1])
                        s_next = '0;
                    else if (snew > (DIV_W+2)'(QONE))
                        s_next = S_W'(QONE);
                    else
                        s_next = S_W'(snew);
                    nit_next   = nit_reg + 1'b1;
                    state_next = (nit_reg == NIT_W'(NEWTON_STEPS - 1)) ? S_BX : S_NX;
                end
            end
            S_BX:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd2)
                begin
                    ph_next    = '0;
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if (hit)
                    state_next = S_Y;
                else
                begin
                    lo_next  = nlo;
                    hi_next  = nhi;
                    s_next   = mid;
                    bit_next = bit_reg + 1'b1;
                    if ((bit_reg == BIT_W'(BISECT_STEPS - 1)) || !(nlo < nhi))
                        state_next = S_Y;
                    else
                        state_next = S_BX;
                end
            end
            S_Y:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd2)
                begin
                    ph_next    = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (acc < ACC_W'(OUT_MIN))
                        out_next = OUT_W'(OUT_MIN);
                    else if (acc > ACC_W'(OUT_MAX))
                        out_next = OUT_W'(OUT_MAX);
                    else
                        out_next = OUT_W'(acc);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= '0;
            nit_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            nit_reg       <= nit_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        t_reg   <= t_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        err_reg <= err_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

endmodule
`default_nettype wire

### rtl/cbez_coef.sv
`default_nettype none
module cbez_coef (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [cbez_pkg::IDX_W-1:0]    wr_index,
    input  wire logic [cbez_pkg::CP_Y_W-1:0]   wr_data,
    output cbez_pkg::coef_t                    coef
);
    import cbez_pkg::*;

    logic        [CP_X_W-1:0] cp1x_reg, cp2x_reg, wx;
    logic signed [CP_Y_W-1:0] cp1y_reg, cp2y_reg;
    logic signed [COEF_W-1:0] ax, bx, ay, by;

    always_comb
    begin
        wx = wr_data[CP_X_W-1:0];
        if (wx > CP_X_W'(QONE))
            wx = CP_X_W'(QONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp1x_reg <= '0;
            cp1y_reg <= '0;
            cp2x_reg <= CP_X_W'(QONE);
            cp2y_reg <= CP_Y_W'(QONE);
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_CP1_X: cp1x_reg <= wx;
                REG_CP1_Y: cp1y_reg <= $signed(wr_data);
                REG_CP2_X: cp2x_reg <= wx;
                REG_CP2_Y: cp2y_reg <= $signed(wr_data);
                default:   cp1x_reg <= cp1x_reg;
            endcase
        end
    end

    always_comb
    begin
        ax = COEF_W'($signed({1'b0, cp1x_reg}));
        bx = COEF_W'($signed({1'b0, cp2x_reg}));
        ay = COEF_W'(cp1y_reg);
        by = COEF_W'(cp2y_reg);
        coef.c2x = COEF_W'(3 * ax);
        coef.c1x = COEF_W'(3 * bx - 6 * ax);
        coef.c0x = COEF_W'(QONE - 3 * bx + 3 * ax);
        coef.c2y = COEF_W'(3 * ay);
        coef.c1y = COEF_W'(3 * by - 6 * ay);
        coef.c0y = COEF_W'(QONE - 3 * by + 3 * ay);
    end

endmodule
`default_nettype wire

### rtl/cbez_mac.sv
`default_nettype none
module cbez_mac (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [cbez_pkg::ACC_W-1:0]  a,
    input  wire logic        [cbez_pkg::S_W-1:0]    s,
    input  wire logic signed [cbez_pkg::ACC_W-1:0]  c,
    output logic signed      [cbez_pkg::ACC_W-1:0]  acc
);
    import cbez_pkg::*;

    localparam int P_W = ACC_W + S_W + 1;

    logic signed [P_W-1:0]   prod, rs;
    logic        [P_W-1:0]   mag, rnd;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // a*s/2^F rounded to nearest, ties away from zero, plus c
    always_comb
    begin
        prod     = P_W'(a) * $signed({1'b0, s});
        mag      = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
        rnd      = (mag + P_W'(QONE / 2)) >> FRAC_BITS;
        rs       = prod[P_W-1] ? -$signed(rnd) : $signed(rnd);
        acc_next = ACC_W'(rs) + c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

### rtl/cbez_div.sv
`default_nettype none
module cbez_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [cbez_pkg::DIV_W-1:0]   num,
    input  wire logic [cbez_pkg::ACC_W-1:0]   den,
    output logic                              done,
    output logic      [cbez_pkg::DIV_W-1:0]   quo
);
    import cbez_pkg::*;

    logic [ACC_W-1:0] rem_reg, rem_next, den_reg;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg, done_reg;
    logic [ACC_W:0]   trial;
    logic             qbit;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? ACC_W'(trial - {1'b0, den_reg}) : trial[ACC_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(DIV_W);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

### rtl/cbez_chk.sv
`default_nettype none
module cbez_chk (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [cbez_pkg::OUT_W-1:0]    eased_value,
    input wire logic                                 cfg_ready
);
    import cbez_pkg::*;

    // held result transaction keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(eased_value))
        else $error("stalled result changed");

    // result saturates to [-2.0, 3.0]
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (eased_value >= OUT_W'(OUT_MIN)) && (eased_value <= OUT_W'(OUT_MAX)))
        else $error("result out of range");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transaction");

    // no item finishes before its y(s) evaluation is through
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##2 in_stall)
        else $error("item finished too early");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind cubic_bezier_easing_solver cbez_chk u_cbez_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .eased_value (eased_value),
    .cfg_ready   (cfg_ready)
);
`default_nettype wire

### tb/sv/easing_checker.sv
`default_nettype none
module easing_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic signed [cbez_pkg::IN_W-1:0]   progress,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic signed [cbez_pkg::OUT_W-1:0]  eased_value,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic        [cbez_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic        [cbez_pkg::CP_Y_W-1:0] cfg_data,
    output int                                      fails,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cbez_pkg::*;

    longint p1x, p1y, p2x, p2y;
    longint cx[3];
    longint cy[3];
    logic signed [OUT_W-1:0] eased_q[$];

    initial fails = 0;

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return (p + QONE / 2) / QONE;
        return -((-p + QONE / 2) / QONE);
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint poly(longint c0, longint c1, longint c2, longint s);
        longint v;
        v = qmul(c0, s) + c1;
        v = qmul(v, s) + c2;
        return qmul(v, s);
    endfunction

    function automatic longint slope(longint s);
        longint v;
        v = qmul(3 * cx[0], s) + 2 * cx[1];
        return qmul(v, s) + cx[2];
    endfunction

    task automatic refresh_coeffs();
        cx[2] = 3 * p1x;
        cx[1] = 3 * (p2x - p1x) - cx[2];
        cx[0] = QONE - cx[2] - cx[1];
        cy[2] = 3 * p1y;
        cy[1] = 3 * (p2y - p1y) - cy[2];
        cy[0] = QONE - cy[2] - cy[1];
    endtask

    function automatic longint solve_s(longint t);
        longint s, lo, hi, err, d, x;
        s = t;
        lo = 0;
        hi = QONE;
        if (t < 0)
            return 0;
        if (t > QONE)
            return QONE;
        for (int i = 0; i < NEWTON_STEPS; i++)
        begin
            err = poly(cx[0], cx[1], cx[2], s) - t;
            if (absl(err) < TOL)
                return s;
            d = slope(s);
            if (d == 0)
                break;
            s = clampl(s - (err * QONE) / d, 0, QONE);
        end
        for (int i = 0; i < BISECT_STEPS && lo < hi; i++)
        begin
            x = poly(cx[0], cx[1], cx[2], s);
            if (absl(x - t) < TOL)
                return s;
            if (t > x)
                lo = s;
            else
                hi = s;
            s = lo + (hi - lo) / 2;
        end
        return s;
    endfunction

    function automatic logic signed [OUT_W-1:0] eased_at(longint t);
        longint y;
        y = clampl(poly(cy[0], cy[1], cy[2], solve_s(t)), OUT_MIN, OUT_MAX);
        return y[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [OUT_W-1:0] want;
        if (!rst_n)
        begin
            p1x = 0;
            p1y = 0;
            p2x = QONE;
            p2y = QONE;
            refresh_coeffs();
            eased_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CP1_X: p1x = clampl(longint'(cfg_data[CP_X_W-1:0]), 0, QONE);
                    REG_CP1_Y: p1y = longint'(signed'(cfg_data));
                    REG_CP2_X: p2x = clampl(longint'(cfg_data[CP_X_W-1:0]), 0, QONE);
                    REG_CP2_Y: p2y = longint'(signed'(cfg_data));
                endcase
                refresh_coeffs();
            end
            if (out_valid && !out_stall)
            begin
                if (eased_q.size() == 0)
                    report_mismatch($sformatf("unexpected eased_value %0d", eased_value));
                else
                begin
                    want = eased_q.pop_front();
                    if (eased_value !== want)
                        report_mismatch($sformatf("eased_value %0d, want %0d",
                                                  eased_value, want));
                end
            end
            if (in_valid && !in_stall)
                eased_q.push_back(eased_at(longint'(progress)));
            pending <= eased_q.size();
        end
    end
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cbez_pkg::*;

    localparam longint LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [IN_W-1:0] progress = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] eased_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CP_Y_W-1:0] cfg_data = '0;
    int fails;
    int pending;
    int tx_pct = 0;
    int rx_pct = 0;
    longint cycles = 0;

    always #1 clk = ~clk;

    cubic_bezier_easing_solver DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .progress(progress),
        .out_valid(out_valid), .out_stall(out_stall), .eased_value(eased_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    easing_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .progress(progress),
        .out_valid(out_valid), .out_stall(out_stall), .eased_value(eased_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < rx_pct);

    task automatic send_progress(logic [IN_W-1:0] t);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        progress <= t;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CP_Y_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_curve(logic [CP_X_W-1:0] ax, logic [CP_Y_W-1:0] ay,
                             logic [CP_X_W-1:0] bx, logic [CP_Y_W-1:0] by);
        drain();
        write_reg(REG_CP1_X, CP_Y_W'(ax));
        write_reg(REG_CP1_Y, ay);
        write_reg(REG_CP2_X, CP_Y_W'(bx));
        write_reg(REG_CP2_Y, by);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_progress();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return IN_W'($urandom);
        if (r < 12)
            case ($urandom_range(5))
                0: return 18'h20000;
                1: return 18'h1FFFF;
                2: return IN_W'(QONE);
                3: return IN_W'(QONE + 1);
                4: return 18'h3FFFF;
                default: return '0;
            endcase
        return IN_W'($urandom_range(QONE, 0));
    endfunction

    task automatic random_curve();
        logic [CP_X_W-1:0] ax, bx;
        logic [CP_Y_W-1:0] ay, by;
        ax = ($urandom_range(99) < 15) ? CP_X_W'($urandom) : CP_X_W'($urandom_range(QONE, 0));
        bx = ($urandom_range(99) < 15) ? CP_X_W'($urandom) : CP_X_W'($urandom_range(QONE, 0));
        ay = ($urandom_range(99) < 15) ? CP_Y_W'($urandom)
                                       : CP_Y_W'(int'($urandom_range(2 * QONE, 0)) - QONE / 2);
        by = ($urandom_range(99) < 15) ? CP_Y_W'($urandom)
                                       : CP_Y_W'(int'($urandom_range(2 * QONE, 0)) - QONE / 2);
        set_curve(ax, ay, bx, by);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: linear curve at reset, then a few shaped curves
        send_progress('0);
        send_progress(IN_W'(QONE));
        send_progress(IN_W'(QONE + 1));
        send_progress(18'h3FFFF);
        send_progress(18'h20000);
        send_progress(18'h1FFFF);
        send_progress(IN_W'(QONE / 2));
        send_progress(18'd1);
        send_progress(IN_W'(QONE - 1));
        // cusp-like x: slope vanishes mid-curve
        set_curve(17'h10000, 19'h3FFFF, 17'h00000, 19'h40000);
        send_progress(IN_W'(QONE / 2));
        send_progress(IN_W'(QONE / 3));
        send_progress(IN_W'(QONE - 100));
        send_progress(18'd50);
        // x out of range gets clamped; y overshoots above 1.0
        set_curve(17'h1FFFF, 19'h30000, 17'h1FFFF, 19'h30000);
        send_progress(IN_W'(QONE / 4));
        send_progress(IN_W'(3 * QONE / 4));
        send_progress(IN_W'(QONE / 2));
        set_curve(17'd27525, 19'd0, 17'd38011, 19'h10000);
        send_progress(IN_W'(QONE / 5));
        send_progress(IN_W'(QONE / 2));
        send_progress(IN_W'(4 * QONE / 5));

        for (int mode = 0; mode < 3; mode++)
        begin
            tx_pct = (mode == 0) ? 35 : (mode == 1) ? 84 : 0;
            rx_pct = (mode == 0) ? 84 : (mode == 1) ? 35 : 0;
            for (int k = 0; k < 4; k++)
            begin
                if (k == 0)
                    set_curve(17'd0, 19'h20000, 17'h10000, 19'h60000);
                else
                    random_curve();
                for (int n = 0; n < 108; n++)
                    send_progress(rand_progress());
            end
        end

        drain();
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/cbez_pkg.sv
rtl/cbez_coef.sv
rtl/cbez_mac.sv
rtl/cbez_div.sv
rtl/cubic_bezier_easing_solver.sv
rtl/cbez_chk.sv
tb/sv/easing_checker.sv
tb/sv/testbench.sv
